@@ sv/mcg_pkg.sv @@
// Shared types and constants of the motion collision gate.
`default_nettype none

package mcg_pkg;

	// field widths
	localparam int DistW  = 10;
	localparam int AgeW   = 16;
	localparam int NumW   = 17;
	localparam int QuoW   = 7;
	localparam int NStage = 8;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_STOP    = 2'd0,
		REG_SLOW    = 2'd1,
		REG_TIMEOUT = 2'd2
	} reg_idx_t;

	// reset values of the configuration registers
	localparam logic [DistW-1:0] StopReset    = 10'd20;
	localparam logic [DistW-1:0] SlowReset    = 10'd50;
	localparam logic [AgeW-1:0]  TimeoutReset = 16'd400;

	// request payload
	typedef struct packed {
		logic signed [7:0]  cmd_linear;
		logic signed [7:0]  cmd_angular;
		logic [AgeW-1:0]    age_ms;
		logic               packet_present;
		logic               estop_flag;
		logic [DistW-1:0]   us_left_cm;
		logic [DistW-1:0]   us_center_cm;
		logic [DistW-1:0]   us_right_cm;
		logic [2:0]         us_fresh_mask;
		logic [4:0]         ir_triggers;
	} cmd_t;

	// result payload
	typedef struct packed {
		logic signed [7:0] safe_linear;
		logic signed [7:0] safe_angular;
		logic              timed_out;
		logic              halted;
		logic              fwd_blocked;
		logic              left_turn_blocked;
		logic              right_turn_blocked;
		logic              reverse_blocked;
	} res_t;

	// configuration register set
	typedef struct packed {
		logic [DistW-1:0] stop_distance_cm;
		logic [DistW-1:0] slowdown_distance_cm;
		logic [AgeW-1:0]  packet_timeout_ms;
	} cfg_t;

	// command fields carried down the pipeline
	typedef struct packed {
		logic signed [7:0] lin;
		logic signed [7:0] ang;
		logic [4:0]        ir;
		logic              timeout;
		logic              estop;
	} ctl_t;

	// front end to divider
	typedef struct packed {
		ctl_t             ctl;
		logic             front;
		logic             stop_fwd;
		logic             scale;
		logic [NumW-1:0]  num;
		logic [DistW-1:0] den;
	} arith_t;

	// divider to output gate
	typedef struct packed {
		ctl_t            ctl;
		logic            front;
		logic            stop_fwd;
		logic            scale;
		logic [QuoW-1:0] quo;
	} quo_t;

endpackage

`default_nettype wire

@@ sv/motion_collision_gate.sv @@
// Motion collision gate: top level with handshake control and configuration port.
//
// Usage:
//   Requests (drive command, packet status, front ultrasonic distances and
//   IR triggers) enter on cmd / cmd_valid and are taken at a clock edge with
//   cmd_valid high and cmd_stall low. Results leave on res / res_valid and are
//   taken when res_valid is high and res_stall is low.
//   The datapath is an eight-stage pipeline: qualify and pick the nearest
//   echo, compare with thresholds, form the scaling product, four divider
//   stages of up to two quotient bits each, and the output gate register.
//   One request is accepted every cycle unless a result stall has filled
//   every stage. The divider stages set the depth.
//   When the receiver stalls, the last stage holds and empty stages behind it
//   keep filling; cmd_stall rises only once every stage holds a request.
//   Reset empties the pipeline and loads the thresholds with 20 cm, 50 cm
//   and a 400 ms timeout. The APB port writes and reads the three registers
//   at byte addresses 0, 4 and 8; write them only while the pipeline is empty.
`default_nettype none

module motion_collision_gate (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	input  wire mcg_pkg::cmd_t cmd,
	output logic               res_valid,
	input  wire logic          res_stall,
	output mcg_pkg::res_t      res,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [3:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int Last = mcg_pkg::NStage - 1;

	mcg_pkg::cfg_t               cfg_q;
	logic [mcg_pkg::NStage-1:0]  valid_q;
	logic [mcg_pkg::NStage-1:0]  rdy;
	mcg_pkg::arith_t             arith;
	mcg_pkg::quo_t               quo;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_distance_cm     <= mcg_pkg::StopReset;
			cfg_q.slowdown_distance_cm <= mcg_pkg::SlowReset;
			cfg_q.packet_timeout_ms    <= mcg_pkg::TimeoutReset;
		end else if (psel && penable && pwrite) begin
			case (mcg_pkg::reg_idx_t'(paddr[3:2]))
				mcg_pkg::REG_STOP: begin
					cfg_q.stop_distance_cm <= pwdata[mcg_pkg::DistW-1:0];
				end
				mcg_pkg::REG_SLOW: begin
					cfg_q.slowdown_distance_cm <= pwdata[mcg_pkg::DistW-1:0];
				end
				mcg_pkg::REG_TIMEOUT: begin
					cfg_q.packet_timeout_ms <= pwdata[mcg_pkg::AgeW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		case (mcg_pkg::reg_idx_t'(paddr[3:2]))
			mcg_pkg::REG_STOP:    prdata = 32'(cfg_q.stop_distance_cm);
			mcg_pkg::REG_SLOW:    prdata = 32'(cfg_q.slowdown_distance_cm);
			mcg_pkg::REG_TIMEOUT: prdata = 32'(cfg_q.packet_timeout_ms);
			default:              prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// a stage may load when it is empty or the next one moves on
	always_comb begin
		rdy[Last] = !valid_q[Last] || !res_stall;
		for (int k = Last - 1; k >= 0; k--) begin
			rdy[k] = !valid_q[k] || rdy[k+1];
		end
	end

	// advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (rdy[0]) begin
				valid_q[0] <= cmd_valid;
			end
			for (int k = 1; k < mcg_pkg::NStage; k++) begin
				if (rdy[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign cmd_stall = !rdy[0];
	assign res_valid = valid_q[Last];

	mcg_front u_front (
		.clk   (clk),
		.load  (rdy[2:0]),
		.cmd   (cmd),
		.cfg   (cfg_q),
		.arith (arith)
	);

	mcg_div u_div (
		.clk   (clk),
		.load  (rdy[6:3]),
		.arith (arith),
		.quo   (quo)
	);

	mcg_gate u_gate (
		.clk  (clk),
		.load (rdy[Last]),
		.quo  (quo),
		.res  (res)
	);

endmodule

`default_nettype wire

@@ sv/mcg_front.sv @@
// Front end: request qualification, nearest echo, thresholds and scaling product.
`default_nettype none

module mcg_front (
	input  wire logic          clk,
	input  wire logic [2:0]    load,
	input  wire mcg_pkg::cmd_t cmd,
	input  wire mcg_pkg::cfg_t cfg,
	output mcg_pkg::arith_t    arith
);

	logic                        ok_l, ok_c, ok_r, ok_lc;
	logic [mcg_pkg::DistW-1:0]   min_lc, min_all;
	logic                        timeout_c;
	logic                        stop_hit, slow_hit;
	logic                        lin_pos;
	logic [mcg_pkg::NumW-1:0]    prod;

	mcg_pkg::ctl_t               ctl_s1, ctl_s2;
	logic [mcg_pkg::DistW-1:0]   min_s1;
	logic                        have_s1;
	logic                        front_s2, stop_s2, slow_s2;
	logic [mcg_pkg::DistW-1:0]   diff_s2, den_s2;
	mcg_pkg::arith_t             arith_s3;

	// stage 1: qualify echoes and take the nearest one
	always_comb begin
		timeout_c = !cmd.packet_present || (cmd.age_ms > cfg.packet_timeout_ms);
		ok_l  = cmd.us_fresh_mask[0] && (cmd.us_left_cm != '0);
		ok_c  = cmd.us_fresh_mask[1] && (cmd.us_center_cm != '0);
		ok_r  = cmd.us_fresh_mask[2] && (cmd.us_right_cm != '0);
		ok_lc = ok_l || ok_c;
		min_lc = (ok_l && (!ok_c || cmd.us_left_cm <= cmd.us_center_cm)) ?
			cmd.us_left_cm : cmd.us_center_cm;
		min_all = (ok_lc && (!ok_r || min_lc <= cmd.us_right_cm)) ? min_lc : cmd.us_right_cm;
	end

	always_ff @(posedge clk) begin
		if (load[0]) begin
			ctl_s1.lin     <= cmd.cmd_linear;
			ctl_s1.ang     <= cmd.cmd_angular;
			ctl_s1.ir      <= cmd.ir_triggers;
			ctl_s1.timeout <= timeout_c;
			ctl_s1.estop   <= cmd.estop_flag;
			min_s1         <= min_all;
			have_s1        <= ok_lc || ok_r;
		end
	end

	// stage 2: compare against the thresholds
	always_comb begin
		stop_hit = !have_s1 || (min_s1 <= cfg.stop_distance_cm);
		slow_hit = !stop_hit && (min_s1 < cfg.slowdown_distance_cm);
	end

	always_ff @(posedge clk) begin
		if (load[1]) begin
			ctl_s2   <= ctl_s1;
			front_s2 <= stop_hit || slow_hit;
			stop_s2  <= stop_hit;
			slow_s2  <= slow_hit;
			diff_s2  <= min_s1 - cfg.stop_distance_cm;
			den_s2   <= cfg.slowdown_distance_cm - cfg.stop_distance_cm;
		end
	end

	// stage 3: scaled numerator for the slowdown band
	always_comb begin
		lin_pos = !ctl_s2.lin[7] && (ctl_s2.lin[6:0] != '0);
		prod    = mcg_pkg::NumW'(ctl_s2.lin[6:0]) * mcg_pkg::NumW'(diff_s2);
	end

	always_ff @(posedge clk) begin
		if (load[2]) begin
			arith_s3.ctl      <= ctl_s2;
			arith_s3.front    <= front_s2;
			arith_s3.stop_fwd <= stop_s2;
			arith_s3.scale    <= slow_s2 && lin_pos;
			arith_s3.num      <= prod;
			arith_s3.den      <= den_s2;
		end
	end

	assign arith = arith_s3;

endmodule

`default_nettype wire

@@ sv/mcg_div.sv @@
// Pipelined restoring divider: up to two quotient bits per stage over four stages.
`default_nettype none

module mcg_div (
	input  wire logic            clk,
	input  wire logic [3:0]      load,
	input  wire mcg_pkg::arith_t arith,
	output mcg_pkg::quo_t        quo
);

	typedef struct packed {
		mcg_pkg::ctl_t                ctl;
		logic                         front;
		logic                         stop_fwd;
		logic                         scale;
		logic [mcg_pkg::DistW-1:0]    den;
		logic [mcg_pkg::NumW-1:0]     rem;
		logic [mcg_pkg::QuoW-1:0]     quo;
	} dstage_t;

	// resolve up to two quotient bits, highest first
	function automatic dstage_t div_bits(dstage_t d, int unsigned hi, int unsigned count);
		dstage_t                  r;
		logic [mcg_pkg::NumW-1:0] shifted;
		logic [2:0]               pos;
		r = d;
		for (int unsigned t = 0; t < 2; t++) begin
			if (t < count) begin
				pos     = 3'(hi - t);
				shifted = mcg_pkg::NumW'(r.den) << pos;
				if (r.rem >= shifted) begin
					r.rem      = r.rem - shifted;
					r.quo[pos] = 1'b1;
				end
			end
		end
		return r;
	endfunction

	dstage_t dv_in;
	dstage_t dv_s4, dv_s5, dv_s6, dv_s7;

	// seed the remainder with the numerator
	always_comb begin
		dv_in.ctl      = arith.ctl;
		dv_in.front    = arith.front;
		dv_in.stop_fwd = arith.stop_fwd;
		dv_in.scale    = arith.scale;
		dv_in.den      = arith.den;
		dv_in.rem      = arith.num;
		dv_in.quo      = '0;
	end

	// advance each stage by its quotient bits
	always_ff @(posedge clk) begin
		if (load[0]) begin
			dv_s4 <= div_bits(dv_in, 6, 2);
		end
		if (load[1]) begin
			dv_s5 <= div_bits(dv_s4, 4, 2);
		end
		if (load[2]) begin
			dv_s6 <= div_bits(dv_s5, 2, 2);
		end
		if (load[3]) begin
			dv_s7 <= div_bits(dv_s6, 0, 1);
		end
	end

	assign quo.ctl      = dv_s7.ctl;
	assign quo.front    = dv_s7.front;
	assign quo.stop_fwd = dv_s7.stop_fwd;
	assign quo.scale    = dv_s7.scale;
	assign quo.quo      = dv_s7.quo;

endmodule

`default_nettype wire

@@ sv/mcg_gate.sv @@
// Output gate: apply timeout, e-stop, scaling and IR blocks; result register.
`default_nettype none

module mcg_gate (
	input  wire logic          clk,
	input  wire logic          load,
	input  wire mcg_pkg::quo_t quo,
	output mcg_pkg::res_t      res
);

	mcg_pkg::res_t     res_c;
	mcg_pkg::res_t     res_s8;
	logic signed [7:0] lin;
	logic signed [7:0] ang;

	// gate the command
	always_comb begin
		res_c = '0;
		lin   = quo.ctl.lin;
		ang   = quo.ctl.ang;
		if (quo.ctl.timeout) begin
			res_c.timed_out = 1'b1;
		end else if (quo.ctl.estop) begin
			res_c.halted = 1'b1;
		end else begin
			// forward stop or slowdown from the nearest echo
			if (quo.stop_fwd && !lin[7]) begin
				lin = '0;
			end else if (quo.scale) begin
				lin = {1'b0, quo.quo};
			end
			// front IRs stop forward motion
			if ((quo.ctl.ir[1:0] != '0) && !lin[7]) begin
				lin = '0;
			end
			// rear IR stops reverse
			if (quo.ctl.ir[4] && lin[7]) begin
				lin = '0;
			end
			// side IRs block turns
			if (quo.ctl.ir[2] && ang[7]) begin
				ang = '0;
			end
			if (quo.ctl.ir[3] && !ang[7]) begin
				ang = '0;
			end
			res_c.safe_linear        = lin;
			res_c.safe_angular       = ang;
			res_c.fwd_blocked        = quo.front || (quo.ctl.ir[1:0] != '0);
			res_c.left_turn_blocked  = quo.ctl.ir[2];
			res_c.right_turn_blocked = quo.ctl.ir[3];
			res_c.reverse_blocked    = quo.ctl.ir[4];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s8 <= res_c;
		end
	end

	assign res = res_s8;

endmodule

`default_nettype wire

@@ verif/mcg_checker.sv @@
// Checker for the motion collision gate: tracks registers, predicts and compares results.
module mcg_checker
	import mcg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	input  wire logic        cmd_stall,
	input  cmd_t             cmd,
	input  wire logic        res_valid,
	input  wire logic        res_stall,
	input  res_t             res,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic [31:0] prdata,
	input  wire logic        pready,
	output int               fail_count,
	output int               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// IR trigger bit positions
	localparam int IrFrontLeft  = 0;
	localparam int IrFrontRight = 1;
	localparam int IrSideLeft   = 2;
	localparam int IrSideRight  = 3;
	localparam int IrRear       = 4;

	logic [DistW-1:0] stop_cm;
	logic [DistW-1:0] slow_cm;
	logic [AgeW-1:0]  tmo_ms;
	res_t             gate_q[$];
	res_t             oldest;
	int               errs = 0;

	task automatic report_mismatch(input string field, input int got, input int wanted);
		$display("%0t ns: %s mismatch, got %0d, expected %0d", $time, field, got, wanted);
		errs++;
	endtask

	// Work out the safe command for one request under the current thresholds
	function automatic res_t predict_gate(cmd_t c);
		int               lin;
		int               ang;
		int               span;
		logic [DistW-1:0] echo_cm [3];
		logic [DistW-1:0] near_cm;
		bit               have;
		res_t             r;

		r = '0;
		// timeout wins over e-stop
		if (!c.packet_present || c.age_ms > tmo_ms) begin
			r.timed_out = 1'b1;
			return r;
		end
		if (c.estop_flag) begin
			r.halted = 1'b1;
			return r;
		end

		lin = c.cmd_linear;
		ang = c.cmd_angular;
		echo_cm[0] = c.us_left_cm;
		echo_cm[1] = c.us_center_cm;
		echo_cm[2] = c.us_right_cm;

		// pick the nearest fresh nonzero echo
		have = 1'b0;
		near_cm = '0;
		for (int i = 0; i < 3; i++) begin
			if (c.us_fresh_mask[i] && echo_cm[i] != '0) begin
				if (!have || echo_cm[i] < near_cm)
					near_cm = echo_cm[i];
				have = 1'b1;
			end
		end

		// stop or scale forward motion
		if (!have || near_cm <= stop_cm) begin
			r.fwd_blocked = 1'b1;
			if (lin > 0)
				lin = 0;
		end else if (near_cm < slow_cm) begin
			r.fwd_blocked = 1'b1;
			if (lin > 0) begin
				span = int'(slow_cm) - int'(stop_cm);
				lin = (lin * (int'(near_cm) - int'(stop_cm))) / span;
			end
		end

		// gate by the IR triggers
		if (c.ir_triggers[IrFrontLeft] || c.ir_triggers[IrFrontRight]) begin
			r.fwd_blocked = 1'b1;
			if (lin > 0)
				lin = 0;
		end
		if (c.ir_triggers[IrSideLeft]) begin
			r.left_turn_blocked = 1'b1;
			if (ang < 0)
				ang = 0;
		end
		if (c.ir_triggers[IrSideRight]) begin
			r.right_turn_blocked = 1'b1;
			if (ang > 0)
				ang = 0;
		end
		if (c.ir_triggers[IrRear]) begin
			r.reverse_blocked = 1'b1;
			if (lin < 0)
				lin = 0;
		end

		r.safe_linear = lin[7:0];
		r.safe_angular = ang[7:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_cm = StopReset;
			slow_cm = SlowReset;
			tmo_ms = TimeoutReset;
			gate_q.delete();
			outstanding <= 0;
			fail_count <= 0;
		end else begin
			// queue the expected result of an accepted request
			if (cmd_valid && !cmd_stall)
				gate_q.push_back(predict_gate(cmd));

			// compare an accepted result with the oldest expectation
			if (res_valid && !res_stall) begin
				if (gate_q.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					oldest = gate_q.pop_front();
					if (res.safe_linear !== oldest.safe_linear)
						report_mismatch("safe_linear", res.safe_linear, oldest.safe_linear);
					if (res.safe_angular !== oldest.safe_angular)
						report_mismatch("safe_angular", res.safe_angular, oldest.safe_angular);
					if (res.timed_out !== oldest.timed_out)
						report_mismatch("timed_out", res.timed_out, oldest.timed_out);
					if (res.halted !== oldest.halted)
						report_mismatch("halted", res.halted, oldest.halted);
					if (res.fwd_blocked !== oldest.fwd_blocked)
						report_mismatch("fwd_blocked", res.fwd_blocked, oldest.fwd_blocked);
					if (res.left_turn_blocked !== oldest.left_turn_blocked)
						report_mismatch("left_turn_blocked", res.left_turn_blocked,
							oldest.left_turn_blocked);
					if (res.right_turn_blocked !== oldest.right_turn_blocked)
						report_mismatch("right_turn_blocked", res.right_turn_blocked,
							oldest.right_turn_blocked);
					if (res.reverse_blocked !== oldest.reverse_blocked)
						report_mismatch("reverse_blocked", res.reverse_blocked,
							oldest.reverse_blocked);
				end
			end

			// track register writes and check read data
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
						REG_STOP:    stop_cm = pwdata[DistW-1:0];
						REG_SLOW:    slow_cm = pwdata[DistW-1:0];
						REG_TIMEOUT: tmo_ms = pwdata[AgeW-1:0];
						default:     ;
					endcase
				end else begin
					case (paddr[3:2])
						REG_STOP:
							if (prdata !== 32'(stop_cm))
								report_mismatch("stop_distance_cm read", prdata, stop_cm);
						REG_SLOW:
							if (prdata !== 32'(slow_cm))
								report_mismatch("slowdown_distance_cm read", prdata, slow_cm);
						REG_TIMEOUT:
							if (prdata !== 32'(tmo_ms))
								report_mismatch("packet_timeout_ms read", prdata, tmo_ms);
						default: ;
					endcase
				end
			end

			outstanding <= gate_q.size();
			fail_count <= errs;
		end
	end

endmodule

@@ verif/motion_collision_gate_tb.sv @@
// Testbench top for the motion collision gate: clock, reset, stimulus and verdict.
module motion_collision_gate_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mcg_pkg::*;

	localparam int         IdleMax    = 6;
	localparam int         NumPhases  = 7;
	localparam int         PhaseItems = 145;
	localparam int         QuietLimit = 4000;
	localparam int         TailCycles = 16;
	localparam logic [3:0] AddrUnused = 4'd12;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cmd_valid = 1'b0;
	cmd_t        cmd       = '0;
	logic        res_stall = 1'b0;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [3:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic        cmd_stall;
	logic        res_valid;
	res_t        res;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          outstanding;
	int          quiet = 0;

	// thresholds in force, used to aim the stimulus
	logic [DistW-1:0] stop_cm = StopReset;
	logic [DistW-1:0] slow_cm = SlowReset;
	logic [AgeW-1:0]  tmo_ms  = TimeoutReset;
	bit               send_busy = 1'b0;

	motion_collision_gate u_top (.*);
	mcg_checker u_chk (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall) || psel) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QuietLimit) begin
				$display("motion_collision_gate test failed");
				$finish;
			end
		end
	end

	// stall the result side for a random number of cycles per request
	initial begin : res_sink
		int gap;
		bit busy;
		busy = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				busy = !busy;
			gap = busy ? 0 : $urandom_range(0, IdleMax);
			if (gap > 0) begin
				res_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!(res_valid && !res_stall))
				@(posedge clk);
		end
	end

	function automatic cmd_t pack_cmd(int lin, int ang, int age, bit present, bit estop,
		int left, int center, int right, int fresh, int ir);
		cmd_t c;
		c.cmd_linear = lin[7:0];
		c.cmd_angular = ang[7:0];
		c.age_ms = age[AgeW-1:0];
		c.packet_present = present;
		c.estop_flag = estop;
		c.us_left_cm = left[DistW-1:0];
		c.us_center_cm = center[DistW-1:0];
		c.us_right_cm = right[DistW-1:0];
		c.us_fresh_mask = fresh[2:0];
		c.ir_triggers = ir[4:0];
		return c;
	endfunction

	// draw a distance, mostly close to the thresholds
	function automatic logic [DistW-1:0] rand_dist();
		int v;
		case ($urandom_range(0, 7))
			0: v = 0;
			1: v = $urandom_range(0, 1023);
			2: v = int'(stop_cm) + int'($urandom_range(0, 4)) - 2;
			3: v = int'(slow_cm) + int'($urandom_range(0, 4)) - 2;
			default: v = $urandom_range(stop_cm, slow_cm);
		endcase
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return v[DistW-1:0];
	endfunction

	// draw a request, mostly present, fresh and in time
	function automatic cmd_t rand_cmd();
		cmd_t c;
		c.cmd_linear = 8'($urandom);
		c.cmd_angular = 8'($urandom);
		c.packet_present = ($urandom_range(0, 15) != 0);
		c.estop_flag = ($urandom_range(0, 9) == 0);
		case ($urandom_range(0, 9))
			0: c.age_ms = 16'($urandom);
			1: c.age_ms = tmo_ms;
			2: c.age_ms = tmo_ms + 1'b1;
			default: c.age_ms = 16'($urandom_range(0, tmo_ms));
		endcase
		c.us_left_cm = rand_dist();
		c.us_center_cm = rand_dist();
		c.us_right_cm = rand_dist();
		c.us_fresh_mask = $urandom_range(0, 1) ? 3'b111 : 3'($urandom_range(0, 7));
		c.ir_triggers = $urandom_range(0, 1) ? 5'd0 : 5'($urandom);
		return c;
	endfunction

	// offer one request after a random gap and hold it until taken
	task automatic send_cmd(cmd_t c);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_busy = !send_busy;
		gap = send_busy ? 0 : $urandom_range(0, IdleMax);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	// drop valid and wait until every result is back
	task automatic drain();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// setup then access; the caller closes the group with apb_idle
	task automatic apb_access(bit wr, logic [3:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
	endtask

	task automatic apb_idle();
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// load a threshold set with junk in the unused upper bits, then read it back
	task automatic load_config(logic [DistW-1:0] stop_v, logic [DistW-1:0] slow_v,
		logic [AgeW-1:0] tmo_v);
		stop_cm = stop_v;
		slow_cm = slow_v;
		tmo_ms = tmo_v;
		apb_access(1'b1, {REG_STOP, 2'b00}, {22'($urandom), stop_v});
		apb_access(1'b1, {REG_SLOW, 2'b00}, {22'($urandom), slow_v});
		apb_access(1'b1, {REG_TIMEOUT, 2'b00}, {16'($urandom), tmo_v});
		apb_access(1'b1, AddrUnused, $urandom);
		apb_access(1'b0, {REG_STOP, 2'b00}, '0);
		apb_access(1'b0, {REG_SLOW, 2'b00}, '0);
		apb_access(1'b0, {REG_TIMEOUT, 2'b00}, '0);
		apb_idle();
	endtask

	initial begin : stimulus
		logic [DistW-1:0] stop_tab [NumPhases];
		logic [DistW-1:0] slow_tab [NumPhases];
		logic [AgeW-1:0]  tmo_tab  [NumPhases];

		stop_tab = '{10'd0, 10'd1023, 10'd100, 10'd1, 10'd30, 10'd0, 10'd0};
		slow_tab = '{10'd1023, 10'd0, 10'd100, 10'd1023, 10'd900, 10'd0, 10'd0};
		tmo_tab  = '{16'd65535, 16'd0, 16'd1000, 16'd1, 16'd200, 16'd0, 16'd0};
		for (int p = NumPhases - 2; p < NumPhases; p++) begin
			stop_tab[p] = 10'($urandom_range(0, 300));
			slow_tab[p] = 10'($urandom_range(0, 1023));
			tmo_tab[p] = 16'($urandom);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests under the reset thresholds
		send_cmd(pack_cmd(127, 127, 0, 0, 0, 100, 100, 100, 7, 0));
		send_cmd(pack_cmd(127, -128, 401, 1, 0, 100, 100, 100, 7, 0));
		send_cmd(pack_cmd(127, -128, 400, 1, 0, 100, 100, 100, 7, 0));
		send_cmd(pack_cmd(-128, 127, 65535, 1, 1, 100, 100, 100, 7, 0));
		send_cmd(pack_cmd(100, 100, 0, 1, 1, 100, 100, 100, 7, 0));
		send_cmd(pack_cmd(127, 0, 0, 1, 0, 5, 5, 5, 0, 0));
		send_cmd(pack_cmd(127, 0, 0, 1, 0, 0, 0, 0, 7, 0));
		send_cmd(pack_cmd(127, 0, 0, 1, 0, 20, 600, 600, 7, 0));
		send_cmd(pack_cmd(127, 0, 0, 1, 0, 900, 21, 900, 7, 0));
		send_cmd(pack_cmd(127, 0, 0, 1, 0, 49, 1023, 1023, 5, 0));
		send_cmd(pack_cmd(127, 0, 0, 1, 0, 50, 50, 50, 7, 0));
		send_cmd(pack_cmd(-128, -128, 0, 1, 0, 1023, 1023, 1023, 7, 0));
		send_cmd(pack_cmd(-50, 0, 0, 1, 0, 30, 30, 30, 7, 0));
		send_cmd(pack_cmd(127, 10, 0, 1, 0, 10, 300, 35, 6, 0));
		send_cmd(pack_cmd(1, 127, 0, 1, 0, 49, 49, 49, 7, 0));
		send_cmd(pack_cmd(127, 0, 0, 1, 0, 1023, 1023, 1023, 7, 1));
		send_cmd(pack_cmd(127, 0, 0, 1, 0, 1023, 1023, 1023, 7, 2));
		send_cmd(pack_cmd(0, -128, 0, 1, 0, 1023, 1023, 1023, 7, 4));
		send_cmd(pack_cmd(0, 127, 0, 1, 0, 1023, 1023, 1023, 7, 8));
		send_cmd(pack_cmd(-128, 0, 0, 1, 0, 1023, 1023, 1023, 7, 16));
		send_cmd(pack_cmd(-128, -128, 0, 1, 0, 40, 40, 40, 7, 31));
		drain();

		// random requests under each threshold set, extremes first
		for (int p = 0; p < NumPhases; p++) begin
			load_config(stop_tab[p], slow_tab[p], tmo_tab[p]);
			for (int n = 0; n < PhaseItems; n++)
				send_cmd(rand_cmd());
			drain();
		end

		repeat (TailCycles) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("motion_collision_gate test passed");
		else
			$display("motion_collision_gate test failed");
		$finish;
	end

endmodule

@@ files.f @@
sv/mcg_pkg.sv
sv/mcg_front.sv
sv/mcg_div.sv
sv/mcg_gate.sv
sv/motion_collision_gate.sv
verif/mcg_checker.sv
verif/motion_collision_gate_tb.sv
